// ===== hdl/hds_pkg.sv =====
`timescale 1ns / 1ps
package hds_pkg;

  localparam int unsigned HdrWords = 18;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  word_index;
    logic [31:0] word_data;
    logic [31:0] nonce;
    logic [31:0] hdr_version;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_part;
    logic [1:0]  part_index;
    logic        is_last;
    logic [63:0] share_difficulty;
  } out_item_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] Iv = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t bswap(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== hdl/hds_stream_if.sv =====
`timescale 1ns / 1ps
interface hds_in_if;
  logic                valid;
  logic                ready;
  hds_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hds_out_if;
  logic                valid;
  logic                ready;
  hds_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/hds_sha_core.sv =====
`timescale 1ns / 1ps
module hds_sha_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [255:0]  state_in,
  input  logic [511:0]  block,
  output logic          done,
  output logic [255:0]  state_out
);
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        busy;
  logic        fin;
  logic [31:0] s0, s1, ws0, ws1, t1, t2, wnew;
  logic [255:0] work;

  always_comb begin
    s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    t1 = h + s1 + ((e & f) ^ (~e & g)) + hds_pkg::round_k(rnd) + w[0];
    t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
    ws0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    ws1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wnew = w[0] + ws0 + w[9] + ws1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {a, b, c, d, e, f, g, h} <= state_in;
      for (int i = 0; i < 16; i++) w[i] <= block[511-32*i -: 32];
    end else if (busy) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
    end
  end

  assign work = {a, b, c, d, e, f, g, h};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      state_out[255-32*i -: 32] = state_in[255-32*i -: 32] + work[255-32*i -: 32];
    end
  end
  assign done = fin;
endmodule

// ===== hdl/header_double_sha256_difficulty_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in       in   cmd, word_index, word_data, nonce, hdr_version
// out      out  hash_part, part_index, is_last, share_difficulty
// A test runs three compressions of 64 rounds on one round unit, then a compare
// step and 64 restoring division steps, and then makes four output transfers;
// the next input is taken only after the fourth.
// The block is not ready meanwhile. Reset is synchronous; the header store is not
// cleared. An output stall holds the current transfer and delays the rest.
module header_double_sha256_difficulty_unit (
  input  logic         clk,
  input  logic         rst,
  hds_in_if.sink       in_ch,
  hds_out_if.source    out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_C1 = 7'b0000010, S_C2 = 7'b0000100,
    S_C3 = 7'b0001000, S_PRE = 7'b0010000, S_DIV = 7'b0100000, S_OUT = 7'b1000000
  } state_t;

  state_t        state;
  logic [31:0]   store [hds_pkg::HdrWords];
  logic [31:0]   nonce, ver;
  logic [255:0]  mid;
  logic [255:0]  hval, rem;
  logic [63:0]   quo;
  logic [5:0]    step;
  logic [1:0]    part;
  logic          sat;
  logic          start;
  logic [255:0]  st_in, st_out;
  logic [511:0]  blk;
  logic          done;
  logic [639:0]  hdr;
  logic [256:0]  sh, diff;

  always_comb begin
    hdr[639 -: 32] = hds_pkg::bswap(ver);
    for (int i = 0; i < 18; i++) hdr[607-32*i -: 32] = hds_pkg::bswap(store[i]);
    hdr[31:0] = hds_pkg::bswap(nonce);
  end

  always_comb begin
    st_in = hds_pkg::Iv;
    blk   = hdr[639:128];
    if (state == S_C2) begin
      st_in = mid;
      blk = {hdr[127:0], 32'h80000000, 288'd0, 64'd640};
    end else if (state == S_C3) begin
      blk = {mid, 32'h80000000, 160'd0, 64'd256};
    end
  end

  hds_sha_core u_core (
    .clk(clk), .rst(rst), .start(start), .state_in(st_in), .block(blk),
    .done(done), .state_out(st_out)
  );

  assign sh   = {rem, 1'b0};
  assign diff = sh - {1'b0, hval};
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && !in_ch.data.cmd &&
        in_ch.data.word_index < 5'(hds_pkg::HdrWords)) begin
      store[in_ch.data.word_index] <= in_ch.data.word_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
      part  <= '0;
    end else begin
      start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.data.cmd) begin
            nonce <= in_ch.data.nonce;
            ver   <= in_ch.data.hdr_version;
            start <= 1'b1;
            state <= S_C1;
          end
        end
        S_C1: if (done) begin
          mid <= st_out; start <= 1'b1; state <= S_C2;
        end
        S_C2: if (done) begin
          mid <= st_out; start <= 1'b1; state <= S_C3;
        end
        S_C3: if (done) begin
          for (int i = 0; i < 8; i++) hval[32*i +: 32] <= hds_pkg::bswap(st_out[255-32*i -: 32]);
          state <= S_PRE;
        end
        S_PRE: begin
          rem  <= {96'd0, 16'hFFFF, 144'd0};
          sat  <= (hval <= {96'd0, 16'hFFFF, 144'd0});
          quo  <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem[255] || !diff[256]) begin
            rem <= diff[255:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= sh[255:0];
            quo <= {quo[62:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd63) begin
            part  <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ch.ready) begin
          part <= part + 2'd1;
          if (part == 2'd3) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.hash_part = {hval[128*part[1] + 64*part[0] +: 64]};
  assign out_ch.data.part_index = part;
  assign out_ch.data.is_last = (part == 2'd3);
  assign out_ch.data.share_difficulty = (part != 2'd3) ? 64'd0 : (sat ? '1 : quo);
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  class hash_scoreboard;
    logic [31:0] job_words [18];
    hds_pkg::out_item_t pending [$];
    int          mismatches;

    function void note_input(hds_pkg::in_item_t it);
      hds_pkg::out_item_t r;
      logic [7:0]  hdr [80];
      logic [7:0]  m [80];
      logic [7:0]  d1 [32];
      logic [7:0]  d2 [32];
      logic [255:0] h;
      logic [63:0]  diff;
      if (it.cmd == 1'b0) begin
        if (it.word_index < hds_pkg::HdrWords) job_words[it.word_index] = it.word_data;
        return;
      end
      for (int b = 0; b < 4; b++) begin
        hdr[b] = it.hdr_version[8*b +: 8];
        hdr[76+b] = it.nonce[8*b +: 8];
      end
      for (int i = 0; i < 18; i++)
        for (int b = 0; b < 4; b++) hdr[4+4*i+b] = job_words[i][8*b +: 8];
      digest_msg(hdr, 80, d1);
      for (int i = 0; i < 80; i++) m[i] = (i < 32) ? d1[i] : 8'h00;
      digest_msg(m, 32, d2);
      for (int i = 0; i < 32; i++) h[8*i +: 8] = d2[i];
      diff = difficulty_of(h);
      for (int k = 0; k < 4; k++) begin
        for (int b = 0; b < 8; b++) r.hash_part[8*b +: 8] = d2[8*k+b];
        r.part_index = k[1:0];
        r.is_last = (k == 3);
        r.share_difficulty = (k == 3) ? diff : 64'd0;
        pending.push_back(r);
      end
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(ref logic [31:0] st [8], input logic [7:0] blk [128], input int base);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[base+4*i], blk[base+4*i+1], blk[base+4*i+2], blk[base+4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = st;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk(i) + w[i];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) st[i] += v[i];
    endfunction

    function logic [31:0] rk(int i);
      logic [31:0] tab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return tab[i];
    endfunction

    function void digest_msg(input logic [7:0] msg [80], input int len,
                             output logic [7:0] dout [32]);
      logic [7:0]  buff [128];
      logic [31:0] st [8];
      logic [63:0] bits;
      int nblk;
      nblk = (len + 9 + 63) / 64;
      bits = 64'(len * 8);
      for (int i = 0; i < 128; i++) buff[i] = (i < len) ? msg[i] : 8'h00;
      buff[len] = 8'h80;
      for (int i = 0; i < 8; i++) buff[nblk*64-1-i] = bits[8*i +: 8];
      for (int i = 0; i < 8; i++) st[i] = hds_pkg::Iv[255-32*i -: 32];
      for (int i = 0; i < nblk; i++) compress(st, buff, 64*i);
      for (int i = 0; i < 8; i++)
        for (int b = 0; b < 4; b++) dout[4*i+b] = st[i][31-8*b -: 8];
    endfunction

    function logic [63:0] difficulty_of(logic [255:0] h);
      logic [256:0] rem;
      logic [63:0]  q;
      if (h == '0) return '1;
      rem = 257'hFFFF << 144;
      if ({1'b0, h} <= rem) return '1;
      q = '0;
      for (int s = 0; s < 64; s++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= {1'b0, h}) begin
          rem = rem - {1'b0, h};
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void check_result(hds_pkg::out_item_t got);
      hds_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  hds_in_if  in_ch ();
  hds_out_if out_ch ();
  hash_scoreboard sb;
  int hold_off = 0;
  bit long_stall = 1'b0;

  header_double_sha256_difficulty_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("testbench: FAIL");
    $finish;
  end

  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (long_stall) begin
        out_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        hold_off <= gap_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(hds_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? 0 : gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic hds_pkg::in_item_t load_item(int idx, logic [31:0] d);
    hds_pkg::in_item_t it;
    it.cmd = 1'b0;
    it.word_index = idx[4:0];
    it.word_data = d;
    it.nonce = $urandom;
    it.hdr_version = $urandom;
    return it;
  endfunction

  function automatic hds_pkg::in_item_t test_item(logic [31:0] n, logic [31:0] v);
    hds_pkg::in_item_t it;
    it.cmd = 1'b1;
    it.word_index = 5'($urandom_range(0, 31));
    it.word_data = $urandom;
    it.nonce = n;
    it.hdr_version = v;
    return it;
  endfunction

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int r;
    sb = new();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 18; i++) send(load_item(i, 32'h0));
    send(test_item(32'h0, 32'h0));
    for (int i = 0; i < 18; i++) send(load_item(i, 32'hFFFFFFFF));
    send(test_item(32'hFFFFFFFF, 32'hFFFFFFFF));
    send(load_item(18, 32'h12345678));
    send(load_item(31, 32'h0));
    send(test_item(32'h0, 32'hFFFFFFFF));
    wait_drain();

    fork
      begin
        long_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        long_stall <= 1'b0;
      end
      begin
        send(test_item($urandom, $urandom));
        send(test_item($urandom, $urandom));
        send(load_item(3, $urandom));
        send(test_item($urandom, $urandom));
      end
    join
    wait_drain();

    sent = 0;
    while (sent < 500) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        send(load_item($urandom_range(0, 17), $urandom));
      end else if (r < 9) begin
        send(test_item($urandom, $urandom));
      end else begin
        send(load_item($urandom_range(18, 31), $urandom));
        sent--;
      end
      sent++;
      idle_gap();
      if (sent == 250) wait_drain();
    end

    wait_drain();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
